>>> rtl/bfba_pkg.sv
// ----------------------------------------------------------------------------
// bfba_pkg - shared types and codes of the best-fit block allocator
// Field widths, operation and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package bfba_pkg;

    localparam int unsigned DW = 13;  // sizes, arena length, byte counts
    localparam int unsigned AW = 12;  // payload offsets

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADPTR  = 2'd2;
    localparam logic [1:0] ST_SMALL   = 2'd3;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_WALK,
        S_A_CHK,
        S_A_POP,
        S_A_AFT,
        S_A_BEST,
        S_F_CHK,
        S_F_P,
        S_F_RN,
        S_F_N,
        S_F_X,
        S_F_W,
        S_DONE
    } t_state;

endpackage

>>> rtl/best_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator_core - best-fit allocator with coalescing
// Keeps an address-ordered, doubly linked list of blocks in a slot memory and
// serves allocate, free and free-byte query requests one at a time.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake               | Beat contents
//  ---------+-----------+-------------------------+------------------------------
//  request  | in        | i_in_valid / o_in_stall | mode, req_size, payload_addr
//  result   | out       | o_out_valid/ i_out_stall| status, granted_addr, free_bytes
//  config   | in        | i_cfg_we (no wait)      | arena_size
//
// A request is accepted in the idle state. A query walks the whole list and
// loads its result into the output register; an allocate walks it, splits the
// best-fitting free block and updates the links; a free walks until it finds
// the block, merges it with any free neighbours and updates the links. At most
// MAX_BLOCKS entries are walked, one entry per cycle through the single read
// port of the slot memory; each link update uses its single write port. Mode 3
// and a too-small arena go straight to the done state. The block is idle again
// in the cycle after the load, so the next request can be accepted then at the
// earliest. After reset, and after every arena_size write, the init state
// rebuilds slot zero while requests are stalled. A result waits in the output
// register while the sink stalls; the next request is already taken in, but
// its result is not loaded until the previous beat has gone.
//
module best_fit_block_allocator_core #(
    parameter int unsigned ARENA_BYTES  = 4096,
    parameter int unsigned HEADER_BYTES = 16,
    parameter int unsigned MAX_BLOCKS   = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [bfba_pkg::DW-1:0] i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_mode,
    input  logic [bfba_pkg::DW-1:0] i_req_size,
    input  logic [bfba_pkg::AW-1:0] i_payload_addr,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_status,
    output logic [bfba_pkg::AW-1:0] o_granted_addr,
    output logic [bfba_pkg::DW-1:0] o_free_bytes
);
    import bfba_pkg::*;

    localparam int unsigned SW = $clog2(MAX_BLOCKS);
    localparam int unsigned TW = SW + 1;
    localparam logic [DW-1:0] HDR = DW'(HEADER_BYTES);
    localparam logic [TW-1:0] TOP_FULL = TW'(MAX_BLOCKS);
    localparam logic [TW-1:0] TOP_INIT = TW'(MAX_BLOCKS - 1);
    localparam logic [DW-1:0] ARENA_RST =
        (ARENA_BYTES < 4096) ? DW'(ARENA_BYTES) : DW'(4096);

    // One slot of the block list.
    typedef struct packed {
        logic [DW-1:0] start;
        logic [DW-1:0] size;
        logic          used;
        logic [SW-1:0] nxt;
        logic [SW-1:0] prv;
    } t_slot;

    // Slot memory and spare-slot stack, both with registered reads.
    t_slot         slot_mem [MAX_BLOCKS];
    logic [SW-1:0] stk_mem  [MAX_BLOCKS];

    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    t_slot         mem_wdata;
    logic [SW-1:0] mem_raddr;
    t_slot         r_q;

    logic          stk_we;
    logic [SW-1:0] stk_waddr;
    logic [SW-1:0] stk_wdata;
    logic [SW-1:0] stk_raddr;
    logic [SW-1:0] r_sq;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        r_q <= slot_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        r_sq <= stk_mem[stk_raddr];
    end

    // Control state.
    t_state        r_state, n_state;
    logic [DW-1:0] r_arena, n_arena;
    // Stack depth, and the lowest depth reached since the last rebuild: an entry
    // below that mark is not read from memory but taken as its position plus one.
    logic [TW-1:0] r_top, n_top;
    logic [TW-1:0] r_mintop, n_mintop;
    logic          r_out_valid;

    // Request and working registers.
    logic [1:0]    r_mode, n_mode;
    logic [DW-1:0] r_req, n_req;
    logic [AW-1:0] r_addr, n_addr;
    logic [SW-1:0] r_cur, n_cur;
    logic          r_found, n_found;
    logic [SW-1:0] r_best, n_best;
    t_slot         r_bent, n_bent;
    logic [DW-1:0] r_sum, n_sum;
    logic [SW-1:0] r_n, n_n;
    logic [SW-1:0] r_nf, n_nf;
    t_slot         r_nent, n_nent;
    logic [SW-1:0] r_x, n_x;
    logic [DW-1:0] r_bound, n_bound;
    logic [1:0]    r_rs, n_rs;
    logic [AW-1:0] r_rg, n_rg;
    logic [DW-1:0] r_rf, n_rf;
    logic [1:0]    r_ostat;
    logic [AW-1:0] r_ogrant;
    logic [DW-1:0] r_ofree;

    logic          load_out;
    logic          live;
    logic [DW-1:0] cfg_clamped;
    logic [DW:0]   split_lim;
    logic [DW:0]   hdr_pos;
    logic          last;

    assign live        = (r_arena >= HDR);
    assign cfg_clamped = (32'(i_cfg_data) > ARENA_BYTES) ? DW'(ARENA_BYTES) : i_cfg_data;
    assign split_lim   = (DW + 1)'(HDR) + (DW + 1)'(r_req);
    assign hdr_pos     = (DW + 1)'(r_q.start) + (DW + 1)'(HDR);
    assign last        = (r_q.nxt == '0);
    assign o_in_stall  = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_arena  = r_arena;
        n_top    = r_top;
        n_mintop = r_mintop;
        n_mode   = r_mode;
        n_req    = r_req;
        n_addr   = r_addr;
        n_cur    = r_cur;
        n_found  = r_found;
        n_best   = r_best;
        n_bent   = r_bent;
        n_sum    = r_sum;
        n_n      = r_n;
        n_nf     = r_nf;
        n_nent   = r_nent;
        n_x      = r_x;
        n_bound  = r_bound;
        n_rs     = r_rs;
        n_rg     = r_rg;
        n_rf     = r_rf;
        load_out = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_q;
        mem_raddr = '0;
        stk_we    = 1'b0;
        stk_waddr = r_top[SW-1:0];
        stk_wdata = '0;
        stk_raddr = '0;

        case (r_state)
            S_INIT: begin
                // Slot zero becomes the one free block of the arena.
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata       = '0;
                mem_wdata.size  = live ? (r_arena - HDR) : '0;
                n_state         = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_mode;
                    n_req   = i_req_size;
                    n_addr  = i_payload_addr;
                    n_cur   = '0;
                    n_found = 1'b0;
                    n_sum   = '0;
                    n_rs    = ST_OK;
                    n_rg    = '0;
                    n_rf    = '0;
                    if (i_mode == MODE_NOP) begin
                        n_state = S_DONE;
                    end else if (!live) begin
                        n_rs    = ST_SMALL;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // r_q holds the slot r_cur; the next slot is fetched at once.
                mem_raddr = r_q.nxt;
                n_cur     = r_q.nxt;
                case (r_mode)
                    MODE_ALLOC: begin
                        if (!r_q.used && (r_q.size >= r_req) &&
                            (!r_found || (r_q.size < r_bent.size))) begin
                            n_found = 1'b1;
                            n_best  = r_cur;
                            n_bent  = r_q;
                        end
                        if (last) begin
                            n_state = S_A_CHK;
                        end
                    end
                    MODE_FREE: begin
                        if (hdr_pos == (DW + 1)'(r_addr)) begin
                            n_found = 1'b1;
                            n_best  = r_cur;
                            n_bent  = r_q;
                            n_state = S_F_CHK;
                        end else if (last) begin
                            n_state = S_F_CHK;
                        end
                    end
                    default: begin
                        if (!r_q.used) begin
                            n_sum = r_sum + r_q.size + HDR;
                        end
                        if (last) begin
                            n_rf    = r_q.used ? r_sum : (r_sum + r_q.size + HDR);
                            n_state = S_DONE;
                        end
                    end
                endcase
            end
            S_A_CHK: begin
                stk_raddr = r_top[SW-1:0] - 1'b1;
                if (!r_found) begin
                    n_rs    = ST_NOFIT;
                    n_state = S_DONE;
                end else if (((DW + 1)'(r_bent.size) > split_lim) && (r_top != '0)) begin
                    n_state = S_A_POP;
                end else begin
                    n_n     = r_bent.nxt;
                    n_state = S_A_BEST;
                end
            end
            S_A_POP: begin
                // Spare slot from the top of the stack takes the leftover.
                if ((r_top - 1'b1) < r_mintop) begin
                    n_n = r_top[SW-1:0];
                end else begin
                    n_n = r_sq;
                end
                n_top = r_top - 1'b1;
                if ((r_top - 1'b1) < r_mintop) begin
                    n_mintop = r_top - 1'b1;
                end
                mem_we          = 1'b1;
                mem_waddr       = n_n;
                mem_wdata.start = r_bent.start + HDR + r_req;
                mem_wdata.size  = r_bent.size - HDR - r_req;
                mem_wdata.used  = 1'b0;
                mem_wdata.nxt   = r_bent.nxt;
                mem_wdata.prv   = r_best;
                mem_raddr       = r_bent.nxt;
                n_state         = (r_bent.nxt != '0) ? S_A_AFT : S_A_BEST;
            end
            S_A_AFT: begin
                mem_we        = 1'b1;
                mem_waddr     = r_bent.nxt;
                mem_wdata     = r_q;
                mem_wdata.prv = r_n;
                n_state       = S_A_BEST;
            end
            S_A_BEST: begin
                mem_we         = 1'b1;
                mem_waddr      = r_best;
                mem_wdata      = r_bent;
                mem_wdata.size = r_req;
                mem_wdata.used = 1'b1;
                mem_wdata.nxt  = r_n;
                n_rg           = AW'(r_bent.start + HDR);
                n_state        = S_DONE;
            end
            S_F_CHK: begin
                mem_raddr = r_bent.prv;
                n_nf      = r_best;
                n_nent    = r_bent;
                if (!r_found || !r_bent.used) begin
                    n_rs    = ST_BADPTR;
                    n_state = S_DONE;
                end else if (r_best != '0) begin
                    n_state = S_F_P;
                end else begin
                    n_state = S_F_RN;
                end
            end
            S_F_P: begin
                // A free predecessor absorbs the released block.
                if (!r_q.used) begin
                    n_nf       = r_bent.prv;
                    n_nent     = r_q;
                    n_nent.nxt = r_bent.nxt;
                    if (r_top < TOP_FULL) begin
                        stk_we    = 1'b1;
                        stk_wdata = r_best;
                        n_top     = r_top + 1'b1;
                    end
                end
                n_state = S_F_RN;
            end
            S_F_RN: begin
                mem_raddr = r_nent.nxt;
                if (r_nent.nxt == '0) begin
                    n_x     = '0;
                    n_bound = r_arena;
                    n_state = S_F_W;
                end else begin
                    n_state = S_F_N;
                end
            end
            S_F_N: begin
                mem_raddr = r_q.nxt;
                if (r_q.used) begin
                    mem_we        = 1'b1;
                    mem_waddr     = r_nent.nxt;
                    mem_wdata     = r_q;
                    mem_wdata.prv = r_nf;
                    n_x           = r_nent.nxt;
                    n_bound       = r_q.start;
                    n_state       = S_F_W;
                end else begin
                    // A free successor is folded in as well.
                    if (r_top < TOP_FULL) begin
                        stk_we    = 1'b1;
                        stk_wdata = r_nent.nxt;
                        n_top     = r_top + 1'b1;
                    end
                    n_x     = r_q.nxt;
                    n_bound = r_arena;
                    n_state = (r_q.nxt == '0) ? S_F_W : S_F_X;
                end
            end
            S_F_X: begin
                mem_we        = 1'b1;
                mem_waddr     = r_x;
                mem_wdata     = r_q;
                mem_wdata.prv = r_nf;
                n_bound       = r_q.start;
                n_state       = S_F_W;
            end
            S_F_W: begin
                // The merged block grows up to the next block or the arena end.
                mem_we          = 1'b1;
                mem_waddr       = r_nf;
                mem_wdata       = r_nent;
                mem_wdata.used  = 1'b0;
                mem_wdata.nxt   = r_x;
                mem_wdata.size  = r_bound - r_nent.start - HDR;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        // A configuration write rebuilds the arena from slot zero.
        if (i_cfg_we) begin
            n_arena  = cfg_clamped;
            n_top    = TOP_INIT;
            n_mintop = TOP_INIT;
            n_state  = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_arena     <= ARENA_RST;
            r_top       <= TOP_INIT;
            r_mintop    <= TOP_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_arena  <= n_arena;
            r_top    <= n_top;
            r_mintop <= n_mintop;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_req   <= n_req;
        r_addr  <= n_addr;
        r_cur   <= n_cur;
        r_found <= n_found;
        r_best  <= n_best;
        r_bent  <= n_bent;
        r_sum   <= n_sum;
        r_n     <= n_n;
        r_nf    <= n_nf;
        r_nent  <= n_nent;
        r_x     <= n_x;
        r_bound <= n_bound;
        r_rs    <= n_rs;
        r_rg    <= n_rg;
        r_rf    <= n_rf;
        if (load_out) begin
            r_ostat  <= r_rs;
            r_ogrant <= r_rg;
            r_ofree  <= r_rf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_ostat;
    assign o_granted_addr = r_ogrant;
    assign o_free_bytes   = r_ofree;

`ifndef SYNTH
    // The spare stack never holds more slots than exist.
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TOP_FULL)
        else $error("spare stack overflow");

    // The rebuilt-contents mark never rises above the stack depth.
    a_mark_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mintop <= r_top)
        else $error("spare stack mark above depth");

    // A small-arena status is only reported when the arena really is small.
    a_small_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && (r_rs == ST_SMALL) |=> !live)
        else $error("small-arena status with a live arena");

    // A granted offset is only given with an ok status.
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_granted_addr == '0))
        else $error("offset granted on failure");
`endif

endmodule
